// ===== sv/cmpb_pkg.sv =====
// Shared types, constants and a helper function of the cube map point binning block.
package cmpb_pkg;

   localparam int DEF_MAX_POINTS = 2048;
   localparam int DEF_MAX_GRID   = 3;

   localparam int FUNC_W   = 2;
   localparam int DIR_W    = 16;
   localparam int SNUM_W   = 11;
   localparam int CELL_W   = 6;
   localparam int STATUS_W = 2;
   localparam int FACE_W   = 3;
   localparam int POS_W    = 8;
   localparam int BOUND_W  = 12;
   localparam int GRID_W   = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_BOUNDS = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_ZERO  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BIN1,
      ST_BIN2,
      ST_INS_A,
      ST_INS_B,
      ST_INS_C,
      ST_SHIFT,
      ST_DRAIN,
      ST_PUT,
      ST_INC,
      ST_INC_END,
      ST_RDS,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_BKT_A,
      ST_BKT_B,
      ST_BKT_C,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     zero;
      logic [FACE_W-1:0]        face;
      logic [CELL_W-1:0]        cell_idx;
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic signed [POS_W-1:0]  pz;
   } bin_res_type;

   typedef struct packed {
      status_type               status;
      logic [FACE_W-1:0]        face;
      logic [CELL_W-1:0]        cell_idx;
      logic [SNUM_W-1:0]        slot;
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic signed [POS_W-1:0]  pz;
      logic [BOUND_W-1:0]       bs;
      logic [BOUND_W-1:0]       be;
   } res_type;

   function automatic logic [FACE_W-1:0] face_of(input logic [CELL_W-1:0] c,
                                                 input logic [3:0] gg);
      logic [FACE_W-1:0] f;
      f = '0;
      for (int k = 1; k < 6; k++) begin
         if (int'(c) >= k * int'(gg)) begin
            f = f + 3'd1;
         end
      end
      return f;
   endfunction

endpackage

// ===== sv/cmpb_bin.sv =====
// Two-stage binning unit: face selection, cell quantization and coordinate bytes.
module cmpb_bin (
   input  logic                               clock,
   input  logic signed [cmpb_pkg::DIR_W-1:0]  dir_x,
   input  logic signed [cmpb_pkg::DIR_W-1:0]  dir_y,
   input  logic signed [cmpb_pkg::DIR_W-1:0]  dir_z,
   input  logic [cmpb_pkg::GRID_W-1:0]        grid,
   output cmpb_pkg::bin_res_type              result
);
   import cmpb_pkg::*;

   logic [16:0]       ax, ay, az, m_in, m_ff;
   logic [FACE_W-1:0] face_in, face_ff;
   logic [DIR_W-1:0]  cu_in, cu_ff, cv_in, cv_ff;
   logic [DIR_W-1:0]  x_ff, y_ff, z_ff;
   logic              zero_in, zero_ff;
   logic [1:0]        u, v;
   logic [3:0]        gg;
   bin_res_type       res_in, res_ff;

   function automatic logic [1:0] quant(input logic [DIR_W-1:0] c, input logic [16:0] m,
                                        input logic [1:0] g);
      logic [18:0] n, ng, m2;
      logic [1:0]  q;
      n  = {{3{c[DIR_W-1]}}, c} + {2'b00, m};
      ng = n * {17'd0, g};
      m2 = {1'b0, m, 1'b0};
      q  = 2'd0;
      if (g >= 2'd2 && ng >= m2) begin
         q = 2'd1;
      end
      if (g == 2'd3 && ng >= m2 + m2) begin
         q = 2'd2;
      end
      return q;
   endfunction

   function automatic logic signed [POS_W-1:0] to_byte(input logic [DIR_W-1:0] c);
      logic signed [23:0] p, q;
      p = $signed({{8{c[DIR_W-1]}}, c}) * 24'sd127;
      if (p < 0) begin
         p = p + 24'sd16383;
      end
      q = p >>> 14;
      if (q > 24'sd127) begin
         q = 24'sd127;
      end
      if (q < -24'sd127) begin
         q = -24'sd127;
      end
      return q[POS_W-1:0];
   endfunction

   always_comb begin
      ax = dir_x[DIR_W-1] ? (17'd0 - {1'b1, dir_x}) : {1'b0, dir_x};
      ay = dir_y[DIR_W-1] ? (17'd0 - {1'b1, dir_y}) : {1'b0, dir_y};
      az = dir_z[DIR_W-1] ? (17'd0 - {1'b1, dir_z}) : {1'b0, dir_z};
      zero_in = (ax == 17'd0) && (ay == 17'd0) && (az == 17'd0);
      priority if (ax >= ay && ax >= az) begin
         m_in    = ax;
         face_in = dir_x[DIR_W-1] ? 3'd0 : 3'd1;
         cu_in   = dir_y;
         cv_in   = dir_z;
      end else if (ay >= az) begin
         m_in    = ay;
         face_in = dir_y[DIR_W-1] ? 3'd2 : 3'd3;
         cu_in   = dir_z;
         cv_in   = dir_x;
      end else begin
         m_in    = az;
         face_in = dir_z[DIR_W-1] ? 3'd4 : 3'd5;
         cu_in   = dir_x;
         cv_in   = dir_y;
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      face_ff <= face_in;
      cu_ff   <= cu_in;
      cv_ff   <= cv_in;
      zero_ff <= zero_in;
      x_ff    <= dir_x;
      y_ff    <= dir_y;
      z_ff    <= dir_z;
   end

   always_comb begin
      gg              = 4'(grid) * 4'(grid);
      u               = quant(cu_ff, m_ff, grid);
      v               = quant(cv_ff, m_ff, grid);
      res_in.zero     = zero_ff;
      res_in.face     = face_ff;
      res_in.cell_idx = 6'(face_ff) * 6'(gg) + 6'(u) + 6'(grid) * 6'(v);
      res_in.px       = to_byte(x_ff);
      res_in.py       = to_byte(y_ff);
      res_in.pz       = to_byte(z_ff);
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

// ===== sv/cube_map_point_binning.sv =====
// Top level of the cube map point binning block with its bucket-sorted point store.
//
//   channel  direction  handshake                 content
//   req      in         req_valid / req_stall     func, direction, slot and cell numbers
//   rsp      out        rsp_valid / rsp_stall     status, face, cell, slot, bytes, bounds
//   csr      in         csr_wr_en                 grid_size
//
// An insert is bounded by the walk that moves the point store up one slot and the pass
// that bumps later bucket offsets. A slot read scans over the offsets to find its bucket.
// Both memories have one read and one write port.
// Reset is synchronous; it empties the table at once through per-bucket valid bits.
// A stalled result waits in the output register while the next request is taken.
module cube_map_point_binning #(
   parameter int MAX_POINTS = cmpb_pkg::DEF_MAX_POINTS,
   parameter int MAX_GRID   = cmpb_pkg::DEF_MAX_GRID
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [cmpb_pkg::FUNC_W-1:0]           req_func,
   input  logic signed [cmpb_pkg::DIR_W-1:0]     req_dir_x,
   input  logic signed [cmpb_pkg::DIR_W-1:0]     req_dir_y,
   input  logic signed [cmpb_pkg::DIR_W-1:0]     req_dir_z,
   input  logic [cmpb_pkg::SNUM_W-1:0]           req_slot_number,
   input  logic [cmpb_pkg::CELL_W-1:0]           req_cell_number,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cmpb_pkg::STATUS_W-1:0]         rsp_status,
   output logic [cmpb_pkg::FACE_W-1:0]           rsp_face,
   output logic [cmpb_pkg::CELL_W-1:0]           rsp_cell_res,
   output logic [cmpb_pkg::SNUM_W-1:0]           rsp_slot,
   output logic signed [cmpb_pkg::POS_W-1:0]     rsp_pos_x,
   output logic signed [cmpb_pkg::POS_W-1:0]     rsp_pos_y,
   output logic signed [cmpb_pkg::POS_W-1:0]     rsp_pos_z,
   output logic [cmpb_pkg::BOUND_W-1:0]          rsp_bucket_start,
   output logic [cmpb_pkg::BOUND_W-1:0]          rsp_bucket_end,
   output logic [cmpb_pkg::BOUND_W-1:0]          rsp_total_points,
   input  logic                                  csr_wr_en,
   input  logic [cmpb_pkg::GRID_W-1:0]           csr_wr_data
);
   import cmpb_pkg::*;

   localparam int AW          = $clog2(MAX_POINTS);
   localparam int CW          = $clog2(MAX_POINTS + 1);
   localparam int NCELLS_MAX  = 6 * MAX_GRID * MAX_GRID;
   localparam int OAW         = $clog2(NCELLS_MAX);

   state_type                state_ff, state_in;
   logic [GRID_W-1:0]        grid_ff;
   logic [GRID_W-1:0]        g_eff;
   logic [3:0]               gg;
   logic [CELL_W-1:0]        ncells;

   logic [DIR_W-1:0]         x_ff, y_ff, z_ff;
   logic [SNUM_W-1:0]        snum_ff;
   logic [CELL_W-1:0]        cnum_ff;

   bin_res_type              bin;

   logic [CW-1:0]            total_ff, total_in;
   logic [NCELLS_MAX-1:0]    valid_ff;
   logic                     clear_req;
   logic [CELL_W-1:0]        k_ff, k_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            pos_ff, pos_in;
   logic [CW-1:0]            bs_ff, bs_in;
   logic [CW-1:0]            prev_ff, prev_in;
   logic [CW-1:0]            snum_ext;

   logic [CW-1:0]            off_mem [NCELLS_MAX];
   logic                     off_rd_en;
   logic [CELL_W-1:0]        off_rd_addr;
   logic [CW-1:0]            off_rd_ff;
   logic                     off_vrd_ff;
   logic [CELL_W-1:0]        off_k_ff;
   logic [CW-1:0]            off_val;
   logic                     inc_en_ff, inc_en_in;
   logic [OAW-1:0]           inc_addr_ff, inc_addr_in;

   logic [3*POS_W-1:0]       st_mem [MAX_POINTS];
   logic                     st_rd_en;
   logic [AW-1:0]            st_rd_addr;
   logic [3*POS_W-1:0]       st_rd_ff;
   logic                     st_put;
   logic                     sw_en_ff, sw_en_in;
   logic [AW-1:0]            sw_addr_ff, sw_addr_in;

   res_type                  res_ff, res_in;
   res_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]            rsp_total_ff, rsp_total_in;

   always_comb begin
      priority if (grid_ff == 2'd0) begin
         g_eff = 2'd1;
      end else if (int'(grid_ff) > MAX_GRID) begin
         g_eff = GRID_W'(MAX_GRID);
      end else begin
         g_eff = grid_ff;
      end
      gg     = 4'(g_eff) * 4'(g_eff);
      ncells = 6'(gg) * 6'd6;
   end

   cmpb_bin u_bin (
      .clock  (clock),
      .dir_x  (x_ff),
      .dir_y  (y_ff),
      .dir_z  (z_ff),
      .grid   (g_eff),
      .result (bin)
   );

   assign off_val  = (off_k_ff == ncells) ? total_ff : (off_vrd_ff ? off_rd_ff : '0);
   assign snum_ext = CW'(snum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grid_ff      <= 2'd2;
         total_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sw_en_ff     <= 1'b0;
         inc_en_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sw_en_ff     <= sw_en_in;
         inc_en_ff    <= inc_en_in;
         total_ff     <= (csr_wr_en || clear_req) ? '0 : total_in;
         if (csr_wr_en) begin
            grid_ff <= csr_wr_data;
         end
         if (csr_wr_en || clear_req) begin
            valid_ff <= '0;
         end else if (inc_en_ff) begin
            valid_ff[inc_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      bs_ff        <= bs_in;
      prev_ff      <= prev_in;
      sw_addr_ff   <= sw_addr_in;
      inc_addr_ff  <= inc_addr_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      rsp_total_ff <= rsp_total_in;
      if (state_ff == ST_IDLE && req_valid) begin
         x_ff    <= req_dir_x;
         y_ff    <= req_dir_y;
         z_ff    <= req_dir_z;
         snum_ff <= req_slot_number;
         cnum_ff <= req_cell_number;
      end
   end

   always_ff @(posedge clock) begin
      if (off_rd_en) begin
         off_rd_ff  <= off_mem[OAW'(off_rd_addr)];
         off_vrd_ff <= valid_ff[OAW'(off_rd_addr)];
         off_k_ff   <= off_rd_addr;
      end
      if (inc_en_ff) begin
         off_mem[inc_addr_ff] <= off_val + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (st_rd_en) begin
         st_rd_ff <= st_mem[st_rd_addr];
      end
      if (sw_en_ff) begin
         st_mem[sw_addr_ff] <= st_rd_ff;
      end else if (st_put) begin
         st_mem[AW'(pos_ff)] <= {bin.px, bin.py, bin.pz};
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      bs_in        = bs_ff;
      prev_in      = prev_ff;
      total_in     = total_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_total_in = rsp_total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      clear_req    = 1'b0;
      off_rd_en    = 1'b0;
      off_rd_addr  = k_ff;
      st_rd_en     = 1'b0;
      st_rd_addr   = AW'(idx_ff - CW'(1));
      st_put       = 1'b0;
      sw_en_in     = 1'b0;
      sw_addr_in   = sw_addr_ff;
      inc_en_in    = 1'b0;
      inc_addr_in  = inc_addr_ff;
      req_stall    = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               unique case (func_type'(req_func))
                  FUNC_INSERT: state_in = ST_BIN1;
                  FUNC_READ:   state_in = ST_RDS;
                  FUNC_BOUNDS: state_in = ST_BKT_A;
                  FUNC_CLEAR:  state_in = ST_DONE;
               endcase
               if (func_type'(req_func) == FUNC_CLEAR) begin
                  clear_req = 1'b1;
               end
            end
         end
         ST_BIN1: state_in = ST_BIN2;
         ST_BIN2: state_in = ST_INS_A;
         ST_INS_A: begin
            if (bin.zero) begin
               res_in.status = STAT_ZERO;
               state_in      = ST_DONE;
            end else begin
               off_rd_en   = 1'b1;
               off_rd_addr = bin.cell_idx;
               state_in    = ST_INS_B;
            end
         end
         ST_INS_B: begin
            bs_in       = off_val;
            off_rd_en   = 1'b1;
            off_rd_addr = bin.cell_idx + 6'd1;
            state_in    = ST_INS_C;
         end
         ST_INS_C: begin
            pos_in          = off_val;
            res_in.face     = bin.face;
            res_in.cell_idx = bin.cell_idx;
            res_in.bs       = BOUND_W'(bs_ff);
            if (total_ff == CW'(MAX_POINTS)) begin
               res_in.status = STAT_FULL;
               res_in.be     = BOUND_W'(off_val);
               state_in      = ST_DONE;
            end else begin
               idx_in   = total_ff;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (idx_ff > pos_ff) begin
               st_rd_en   = 1'b1;
               sw_en_in   = 1'b1;
               sw_addr_in = AW'(idx_ff);
               idx_in     = idx_ff - CW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_PUT;
         ST_PUT: begin
            st_put   = 1'b1;
            k_in     = bin.cell_idx + 6'd1;
            state_in = ST_INC;
         end
         ST_INC: begin
            if (k_ff < ncells) begin
               off_rd_en   = 1'b1;
               off_rd_addr = k_ff;
               inc_en_in   = 1'b1;
               inc_addr_in = OAW'(k_ff);
               k_in        = k_ff + 6'd1;
            end else begin
               state_in = ST_INC_END;
            end
         end
         ST_INC_END: begin
            total_in      = total_ff + CW'(1);
            res_in.status = STAT_OK;
            res_in.slot   = SNUM_W'(pos_ff);
            res_in.px     = bin.px;
            res_in.py     = bin.py;
            res_in.pz     = bin.pz;
            res_in.be     = BOUND_W'(pos_ff + CW'(1));
            state_in      = ST_DONE;
         end
         ST_RDS: begin
            if (snum_ext >= total_ff || 32'(snum_ff) >= MAX_POINTS) begin
               res_in.status = STAT_RANGE;
               state_in      = ST_DONE;
            end else begin
               st_rd_en   = 1'b1;
               st_rd_addr = AW'(snum_ff);
               k_in       = 6'd1;
               prev_in    = '0;
               state_in   = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            off_rd_en   = 1'b1;
            off_rd_addr = k_ff;
            state_in    = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (snum_ext < off_val) begin
               res_in.status   = STAT_OK;
               res_in.cell_idx = k_ff - 6'd1;
               res_in.face     = face_of(k_ff - 6'd1, gg);
               res_in.slot     = snum_ff;
               res_in.px       = st_rd_ff[3*POS_W-1:2*POS_W];
               res_in.py       = st_rd_ff[2*POS_W-1:POS_W];
               res_in.pz       = st_rd_ff[POS_W-1:0];
               res_in.bs       = BOUND_W'(prev_ff);
               res_in.be       = BOUND_W'(off_val);
               state_in        = ST_DONE;
            end else begin
               prev_in  = off_val;
               k_in     = k_ff + 6'd1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_BKT_A: begin
            if (cnum_ff >= ncells) begin
               res_in.status = STAT_RANGE;
               state_in      = ST_DONE;
            end else begin
               off_rd_en   = 1'b1;
               off_rd_addr = cnum_ff;
               state_in    = ST_BKT_B;
            end
         end
         ST_BKT_B: begin
            bs_in       = off_val;
            off_rd_en   = 1'b1;
            off_rd_addr = cnum_ff + 6'd1;
            state_in    = ST_BKT_C;
         end
         ST_BKT_C: begin
            res_in.status   = STAT_OK;
            res_in.cell_idx = cnum_ff;
            res_in.face     = face_of(cnum_ff, gg);
            res_in.bs       = BOUND_W'(bs_ff);
            res_in.be       = BOUND_W'(off_val);
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_total_in = total_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_face         = rsp_ff.face;
   assign rsp_cell_res     = rsp_ff.cell_idx;
   assign rsp_slot         = rsp_ff.slot;
   assign rsp_pos_x        = rsp_ff.px;
   assign rsp_pos_y        = rsp_ff.py;
   assign rsp_pos_z        = rsp_ff.pz;
   assign rsp_bucket_start = rsp_ff.bs;
   assign rsp_bucket_end   = rsp_ff.be;
   assign rsp_total_points = BOUND_W'(rsp_total_ff);

endmodule

// ===== sv/cmpb_checker.sv =====
// Port-level assertions of the cube map point binning block and their bind.
module cmpb_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [cmpb_pkg::STATUS_W-1:0]         rsp_status,
   input logic [cmpb_pkg::FACE_W-1:0]           rsp_face,
   input logic [cmpb_pkg::CELL_W-1:0]           rsp_cell_res,
   input logic [cmpb_pkg::SNUM_W-1:0]           rsp_slot,
   input logic signed [cmpb_pkg::POS_W-1:0]     rsp_pos_x,
   input logic signed [cmpb_pkg::POS_W-1:0]     rsp_pos_y,
   input logic signed [cmpb_pkg::POS_W-1:0]     rsp_pos_z,
   input logic [cmpb_pkg::BOUND_W-1:0]          rsp_bucket_start,
   input logic [cmpb_pkg::BOUND_W-1:0]          rsp_bucket_end,
   input logic [cmpb_pkg::BOUND_W-1:0]          rsp_total_points
);
   import cmpb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_status)
         && $stable(rsp_total_points) && $stable(rsp_bucket_end))
      else $error("Stalled result transaction changed.");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_ZERO |-> rsp_face == '0 && rsp_cell_res == '0
         && rsp_slot == '0 && rsp_bucket_end == '0 && rsp_pos_x == '0)
      else $error("Zero vector result carries nonzero fields.");

   a_range_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_RANGE |-> rsp_bucket_start == '0
         && rsp_bucket_end == '0 && rsp_pos_y == '0 && rsp_pos_z == '0)
      else $error("Out-of-range result carries nonzero fields.");

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bucket_start <= rsp_bucket_end
         && rsp_bucket_end <= rsp_total_points)
      else $error("Bucket bounds are out of order.");

   a_face_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_face <= 3'd5 && rsp_cell_res <= 6'd53)
      else $error("Face or cell index out of range.");

endmodule

bind cube_map_point_binning cmpb_checker u_cmpb_checker (.*);

// ===== bench/tb_cube_map_point_binning.sv =====
// Self-checking testbench of the cube map point binning block with a behavioral store model.
module tb_cube_map_point_binning;
   import cmpb_pkg::*;

   localparam int NPTS = 2048;
   localparam int NOFF = 55;
   localparam longint CYCLE_LIMIT = 64'd3000000;

   typedef struct packed {
      status_type              status;
      logic [FACE_W-1:0]       face;
      logic [CELL_W-1:0]       cell_idx;
      logic [SNUM_W-1:0]       slot;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pz;
      logic [BOUND_W-1:0]      bs;
      logic [BOUND_W-1:0]      be;
      logic [BOUND_W-1:0]      total;
   } tb_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FUNC_W-1:0] req_func = '0;
   logic signed [DIR_W-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [SNUM_W-1:0] req_slot_number = '0;
   logic [CELL_W-1:0] req_cell_number = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [FACE_W-1:0] rsp_face;
   logic [CELL_W-1:0] rsp_cell_res;
   logic [SNUM_W-1:0] rsp_slot;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [BOUND_W-1:0] rsp_bucket_start, rsp_bucket_end, rsp_total_points;
   logic csr_wr_en = 1'b0;
   logic [GRID_W-1:0] csr_wr_data = '0;

   cube_map_point_binning u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic signed [POS_W-1:0] store_x [NPTS];
   logic signed [POS_W-1:0] store_y [NPTS];
   logic signed [POS_W-1:0] store_z [NPTS];
   int unsigned offsets [NOFF];
   logic [GRID_W-1:0] grid_reg = 2'd2;
   tb_result_type pending_results [$];
   int errors = 0;
   longint cycles = 0;
   bit quiet_phase = 1'b0;

   function automatic int unsigned grid_eff();
      return (grid_reg == 2'd0) ? 1 : int'(grid_reg);
   endfunction

   function automatic logic signed [POS_W-1:0] coord_byte(int c);
      int q;
      q = (c * 127) / 16384;
      if (q > 127) q = 127;
      if (q < -127) q = -127;
      return q[POS_W-1:0];
   endfunction

   function automatic int unsigned cell_of(int c, int unsigned m, int unsigned g);
      int unsigned u;
      u = (unsigned'(c + int'(m)) * g) / (2 * m);
      return (u >= g) ? g - 1 : u;
   endfunction

   function automatic tb_result_type bin_point(func_type f, int x, int y, int z,
                                               int unsigned sn, int unsigned cn);
      tb_result_type r;
      int unsigned g, nc, ax, ay, az, m, u, v, c, fc, tot, pos;
      r = '0;
      g = grid_eff();
      nc = 6 * g * g;
      case (f)
         FUNC_INSERT: begin
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            az = (z < 0) ? -z : z;
            if (ax == 0 && ay == 0 && az == 0) begin
               r.status = STAT_ZERO;
            end else begin
               if (ax >= ay && ax >= az) begin
                  m = ax; fc = (x < 0) ? 0 : 1;
                  u = cell_of(y, m, g); v = cell_of(z, m, g);
               end else if (ay >= az) begin
                  m = ay; fc = (y < 0) ? 2 : 3;
                  u = cell_of(z, m, g); v = cell_of(x, m, g);
               end else begin
                  m = az; fc = (z < 0) ? 4 : 5;
                  u = cell_of(x, m, g); v = cell_of(y, m, g);
               end
               c = fc * g * g + u + g * v;
               r.face = FACE_W'(fc);
               r.cell_idx = CELL_W'(c);
               tot = offsets[nc];
               if (tot >= NPTS) begin
                  r.status = STAT_FULL;
               end else begin
                  pos = offsets[c + 1];
                  for (int i = tot; i > int'(pos); i--) begin
                     store_x[i] = store_x[i-1];
                     store_y[i] = store_y[i-1];
                     store_z[i] = store_z[i-1];
                  end
                  r.px = coord_byte(x); r.py = coord_byte(y); r.pz = coord_byte(z);
                  store_x[pos] = r.px; store_y[pos] = r.py; store_z[pos] = r.pz;
                  for (int i = c + 1; i <= int'(nc); i++) offsets[i]++;
                  r.slot = SNUM_W'(pos);
               end
               r.bs = BOUND_W'(offsets[c]);
               r.be = BOUND_W'(offsets[c + 1]);
            end
         end
         FUNC_READ: begin
            if (sn >= offsets[nc]) begin
               r.status = STAT_RANGE;
            end else begin
               c = 0;
               while (c + 1 < nc && sn >= offsets[c + 1]) c++;
               r.slot = SNUM_W'(sn);
               r.px = store_x[sn]; r.py = store_y[sn]; r.pz = store_z[sn];
               r.cell_idx = CELL_W'(c); r.face = FACE_W'(c / (g * g));
               r.bs = BOUND_W'(offsets[c]); r.be = BOUND_W'(offsets[c + 1]);
            end
         end
         FUNC_BOUNDS: begin
            if (cn >= nc) begin
               r.status = STAT_RANGE;
            end else begin
               r.cell_idx = CELL_W'(cn); r.face = FACE_W'(cn / (g * g));
               r.bs = BOUND_W'(offsets[cn]); r.be = BOUND_W'(offsets[cn + 1]);
            end
         end
         default: begin
            foreach (offsets[i]) offsets[i] = 0;
         end
      endcase
      r.total = BOUND_W'(offsets[nc]);
      return r;
   endfunction

   function automatic bit idle_now();
      return !quiet_phase && ($urandom_range(99) < 10);
   endfunction

   task automatic send_request(func_type f, int x, int y, int z, int unsigned sn,
                               int unsigned cn);
      @(posedge clock);
      while (idle_now()) @(posedge clock);
      req_valid <= 1'b1;
      req_func <= f;
      req_dir_x <= x[DIR_W-1:0];
      req_dir_y <= y[DIR_W-1:0];
      req_dir_z <= z[DIR_W-1:0];
      req_slot_number <= sn[SNUM_W-1:0];
      req_cell_number <= cn[CELL_W-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(bin_point(f, x, y, z, sn, cn));
      req_valid <= 1'b0;
   endtask

   task automatic write_grid(int unsigned val);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= val[GRID_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      grid_reg = val[GRID_W-1:0];
      foreach (offsets[i]) offsets[i] = 0;
   endtask

   function automatic int rand_comp();
      case ($urandom_range(5))
         0: return 16384;
         1: return -16384;
         2: return 0;
         3: return int'($urandom_range(32767)) - 16384;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   task automatic random_insert();
      send_request(FUNC_INSERT, rand_comp(), rand_comp(), rand_comp(), 0, 0);
   endtask

   task automatic random_op();
      int unsigned k, tot;
      k = $urandom_range(99);
      tot = offsets[6 * grid_eff() * grid_eff()];
      if (k < 55) begin
         random_insert();
      end else if (k < 75) begin
         send_request(FUNC_READ, $urandom, $urandom, $urandom,
                      (tot > 0 && $urandom_range(3) != 0) ? $urandom_range(tot - 1)
                                                          : $urandom_range(2047), 0);
      end else if (k < 97) begin
         send_request(FUNC_BOUNDS, $urandom, $urandom, $urandom, 0, $urandom_range(63));
      end else begin
         send_request(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic test_directed();
      send_request(FUNC_INSERT, 0, 0, 0, 0, 0);
      send_request(FUNC_INSERT, 16384, 16384, 16384, 0, 0);
      send_request(FUNC_INSERT, -16384, 0, 0, 0, 0);
      send_request(FUNC_INSERT, 0, -16384, 16384, 0, 0);
      send_request(FUNC_INSERT, 0, 100, -16384, 0, 0);
      send_request(FUNC_INSERT, 32767, -32768, 5, 0, 0);
      send_request(FUNC_INSERT, -32768, 32767, -1, 0, 0);
      send_request(FUNC_INSERT, 1, 0, 0, 0, 0);
      send_request(FUNC_READ, 0, 0, 0, 0, 0);
      send_request(FUNC_READ, 0, 0, 0, 6, 0);
      send_request(FUNC_READ, 0, 0, 0, 7, 0);
      send_request(FUNC_READ, 0, 0, 0, 2047, 0);
      send_request(FUNC_BOUNDS, 0, 0, 0, 0, 0);
      send_request(FUNC_BOUNDS, 0, 0, 0, 0, 23);
      send_request(FUNC_BOUNDS, 0, 0, 0, 0, 24);
      send_request(FUNC_BOUNDS, 0, 0, 0, 0, 63);
      send_request(FUNC_CLEAR, 0, 0, 0, 0, 0);
      send_request(FUNC_READ, 0, 0, 0, 0, 0);
   endtask

   task automatic test_grid_settings();
      for (int unsigned gv = 0; gv < 4; gv++) begin
         write_grid(gv);
         repeat (15) random_insert();
         repeat (15) random_op();
      end
   endtask

   task automatic test_random_traffic();
      write_grid(3);
      repeat (60) random_op();
      quiet_phase = 1'b1;
      repeat (40) random_op();
      quiet_phase = 1'b0;
      write_grid(1);
      repeat (60) random_op();
   endtask

   always @(posedge clock) begin
      rsp_stall <= idle_now();
   end

   always @(posedge clock) begin
      tb_result_type exp_r, act_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         act_r = {status_type'(rsp_status), rsp_face, rsp_cell_res, rsp_slot, rsp_pos_x,
                  rsp_pos_y, rsp_pos_z, rsp_bucket_start, rsp_bucket_end,
                  rsp_total_points};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $time, act_r);
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (exp_r.status != act_r.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                        act_r.status);
               errors++;
            end
            if (exp_r.face != act_r.face) begin
               $display("%0t: face expected %0d actual %0d", $time, exp_r.face, act_r.face);
               errors++;
            end
            if (exp_r.cell_idx != act_r.cell_idx) begin
               $display("%0t: cell expected %0d actual %0d", $time, exp_r.cell_idx,
                        act_r.cell_idx);
               errors++;
            end
            if (exp_r.slot != act_r.slot) begin
               $display("%0t: slot expected %0d actual %0d", $time, exp_r.slot, act_r.slot);
               errors++;
            end
            if (exp_r.px != act_r.px) begin
               $display("%0t: pos_x expected %0d actual %0d", $time, exp_r.px, act_r.px);
               errors++;
            end
            if (exp_r.py != act_r.py) begin
               $display("%0t: pos_y expected %0d actual %0d", $time, exp_r.py, act_r.py);
               errors++;
            end
            if (exp_r.pz != act_r.pz) begin
               $display("%0t: pos_z expected %0d actual %0d", $time, exp_r.pz, act_r.pz);
               errors++;
            end
            if (exp_r.bs != act_r.bs) begin
               $display("%0t: bucket_start expected %0d actual %0d", $time, exp_r.bs,
                        act_r.bs);
               errors++;
            end
            if (exp_r.be != act_r.be) begin
               $display("%0t: bucket_end expected %0d actual %0d", $time, exp_r.be,
                        act_r.be);
               errors++;
            end
            if (exp_r.total != act_r.total) begin
               $display("%0t: total_points expected %0d actual %0d", $time, exp_r.total,
                        act_r.total);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int waited;
      foreach (offsets[i]) offsets[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_grid_settings();
      test_random_traffic();
      waited = 0;
      while (pending_results.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== cube_map_point_binning.f =====
sv/cmpb_pkg.sv
sv/cmpb_bin.sv
sv/cube_map_point_binning.sv
sv/cmpb_checker.sv
bench/tb_cube_map_point_binning.sv
